// ===== hw/rtl/fta_pkg.sv =====
// Shared types and constants for the fused track id association block.
// No dependencies; every other file in hw/rtl uses it.
`timescale 1ns / 1ps

package fta_pkg;

    localparam int SENSORS       = 4;
    localparam int ENTRIES       = 64;
    localparam int TRACK_ID_BITS = 16;
    localparam int FID_BITS      = 32;

    typedef logic [SENSORS-1:0]                     t_mask;
    typedef logic [SENSORS-1:0][TRACK_ID_BITS-1:0] t_ids;
    typedef logic [FID_BITS-1:0]                    t_fid;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    // search token handed from cell to cell
    typedef struct packed {
        logic    active;
        logic    done;
        logic    is_new;
        t_fid    fid;
        t_status status;
    } t_tok;

    // trace under search plus allocation info, broadcast to all cells
    typedef struct packed {
        t_mask mask;
        t_ids  ids;
        t_fid  new_id;
        logic  exhausted;
    } t_query;

    typedef struct packed {
        t_fid    fid;
        logic    is_new;
        t_status status;
    } t_result;

endpackage

// ===== hw/rtl/fta_if.sv =====
// Handshake interfaces for the trace input word and the result output word.
// Depends on fta_pkg.
`timescale 1ns / 1ps

interface fta_in_if;
    logic                              valid;
    logic                              ready;
    logic [fta_pkg::SENSORS-1:0]       present_mask;
    logic [fta_pkg::TRACK_ID_BITS-1:0] track_id_0;
    logic [fta_pkg::TRACK_ID_BITS-1:0] track_id_1;
    logic [fta_pkg::TRACK_ID_BITS-1:0] track_id_2;
    logic [fta_pkg::TRACK_ID_BITS-1:0] track_id_3;

    modport source (output valid, present_mask, track_id_0, track_id_1, track_id_2,
                    track_id_3, input ready);
    modport sink   (input valid, present_mask, track_id_0, track_id_1, track_id_2,
                    track_id_3, output ready);
endinterface

interface fta_out_if;
    logic                         valid;
    logic                         ready;
    logic [fta_pkg::FID_BITS-1:0] fused_id;
    logic                         is_new;
    logic [1:0]                   status;

    modport source (output valid, fused_id, is_new, status, input ready);
    modport sink   (input valid, fused_id, is_new, status, output ready);
endinterface

// ===== hw/rtl/fta_cell.sv =====
// One table entry of the association chain: holds a stored trace and its
// fused id, compares it against the passing token. Depends on fta_pkg.
`timescale 1ns / 1ps

module fta_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fta_pkg::t_tok   i_tok,
    input  fta_pkg::t_query i_query,
    output fta_pkg::t_tok   o_tok
);

    logic             r_valid;
    fta_pkg::t_mask   r_mask;
    fta_pkg::t_ids    r_ids;
    fta_pkg::t_fid    r_fid;
    fta_pkg::t_tok    r_tok;

    fta_pkg::t_tok    n_tok;
    fta_pkg::t_mask   w_shared;
    logic             w_match;
    logic             w_store;
    logic             w_alloc;

    always_comb begin
        w_shared = r_mask & i_query.mask;
        w_match  = (w_shared != '0);
        for (int s = 0; s < fta_pkg::SENSORS; s++) begin
            if (w_shared[s] && (r_ids[s] != i_query.ids[s])) begin
                w_match = 1'b0;
            end
        end
    end

    // valid entries form a prefix, so the first free cell ends the search
    always_comb begin
        n_tok   = i_tok;
        w_store = 1'b0;
        w_alloc = 1'b0;
        if (i_tok.active && !i_tok.done) begin
            if (r_valid && w_match) begin
                w_store      = 1'b1;
                n_tok.done   = 1'b1;
                n_tok.is_new = 1'b0;
                n_tok.fid    = r_fid;
                n_tok.status = fta_pkg::ST_OK;
            end else if (!r_valid) begin
                n_tok.done = 1'b1;
                if (i_query.exhausted) begin
                    n_tok.is_new = 1'b0;
                    n_tok.fid    = '0;
                    n_tok.status = fta_pkg::ST_FULL;
                end else begin
                    w_store      = 1'b1;
                    w_alloc      = 1'b1;
                    n_tok.is_new = 1'b1;
                    n_tok.fid    = i_query.new_id;
                    n_tok.status = fta_pkg::ST_OK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (w_alloc) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mask <= i_query.mask;
            r_ids  <= i_query.ids;
        end
        if (w_alloc) begin
            r_fid <= i_query.new_id;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/fused_track_id_association.sv =====
// Top level of the fused track id association block: input/output handshake,
// id counter and the chain of entry cells. Depends on fta_pkg, fta_if, fta_cell.
`timescale 1ns / 1ps

// Channel    Dir  Word
// i_trace    in   present_mask, track_id_0..3
// o_result   out  fused_id, is_new, status
//
// One trace at a time. An accepted trace is latched, then a search token
// walks the row of ENTRIES cells, one cell per cycle, and the outcome lands in
// the pending result register; an empty trace goes straight to the pending
// register on accept. The result then moves into the output register, and the
// next trace is taken in the cycle after that, while that word still waits.
// Reset (i_rst_n low at a clock edge) clears all entries and the id counter.
// A stall on o_result holds the output word; a second finished result waits
// in the pending register and blocks new traces until it moves.

module fused_track_id_association (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fta_in_if.sink      i_trace,
    fta_out_if.source   o_result
);

    fta_pkg::t_state  r_state;
    fta_pkg::t_state  n_state;

    fta_pkg::t_mask   r_qmask;
    fta_pkg::t_ids    r_qids;
    fta_pkg::t_fid    r_next_id;
    fta_pkg::t_tok    r_start;
    fta_pkg::t_tok    n_start;

    logic             r_pend_valid;
    fta_pkg::t_result r_pend;
    logic             r_out_valid;
    fta_pkg::t_result r_out;

    fta_pkg::t_tok    w_tok [0:fta_pkg::ENTRIES];
    logic [fta_pkg::ENTRIES-1:0] w_act;
    fta_pkg::t_ids    w_raw_ids;
    fta_pkg::t_ids    w_ids;
    fta_pkg::t_query  w_query;
    logic             w_in_ready;
    logic             w_accept;
    logic             w_empty;
    logic             w_walk_done;
    fta_pkg::t_tok    w_last;

    // ---- input side ----
    assign w_raw_ids[0] = i_trace.track_id_0;
    assign w_raw_ids[1] = i_trace.track_id_1;
    assign w_raw_ids[2] = i_trace.track_id_2;
    assign w_raw_ids[3] = i_trace.track_id_3;

    // ids of absent slots are stored as zero
    always_comb begin
        for (int s = 0; s < fta_pkg::SENSORS; s++) begin
            w_ids[s] = i_trace.present_mask[s] ? w_raw_ids[s] : '0;
        end
    end

    assign w_in_ready    = (r_state == fta_pkg::S_IDLE) && !r_pend_valid;
    assign i_trace.ready = w_in_ready;
    assign w_accept      = i_trace.valid && w_in_ready;
    assign w_empty       = (i_trace.present_mask == '0);

    assign w_last      = w_tok[fta_pkg::ENTRIES];
    assign w_walk_done = (r_state == fta_pkg::S_WALK) && w_last.active;

    // ---- control FSM ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fta_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fta_pkg::S_IDLE: begin
                if (w_accept && !w_empty) begin
                    n_state = fta_pkg::S_WALK;
                end
            end
            fta_pkg::S_WALK: begin
                if (w_last.active) begin
                    n_state = fta_pkg::S_IDLE;
                end
            end
            default: n_state = fta_pkg::S_IDLE;
        endcase
    end

    // ---- query latch and start token ----
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_qmask <= i_trace.present_mask;
            r_qids  <= w_ids;
        end
    end

    // allocation info follows the counter; stable during a walk
    always_comb begin
        w_query.mask      = r_qmask;
        w_query.ids       = r_qids;
        w_query.new_id    = r_next_id + fta_pkg::t_fid'(1);
        w_query.exhausted = (r_next_id == '1);
    end

    always_comb begin
        n_start        = '0;
        n_start.active = w_accept && !w_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else begin
            r_start <= n_start;
        end
    end

    // ---- chain of entry cells ----
    assign w_tok[0] = r_start;

    for (genvar e = 0; e < fta_pkg::ENTRIES; e++) begin : g_cell
        fta_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[e]),
            .i_query (w_query),
            .o_tok   (w_tok[e+1])
        );
        assign w_act[e] = w_tok[e+1].active;
    end

    // ---- id counter: holds the last id handed out ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id <= '0;
        end else if (w_walk_done && w_last.done && w_last.is_new) begin
            r_next_id <= w_last.fid;
        end
    end

    // ---- pending result and output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_pend_valid && (!r_out_valid || o_result.ready)) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_walk_done || (w_accept && w_empty)) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_valid && (!r_out_valid || o_result.ready)) begin
            r_out <= r_pend;
        end
        if (w_accept && w_empty) begin
            r_pend.fid    <= '0;
            r_pend.is_new <= 1'b0;
            r_pend.status <= fta_pkg::ST_EMPTY;
        end else if (w_walk_done) begin
            // token that ran off the end unresolved means the table is full
            r_pend.fid    <= w_last.done ? w_last.fid : '0;
            r_pend.is_new <= w_last.done && w_last.is_new;
            r_pend.status <= w_last.done ? w_last.status : fta_pkg::ST_FULL;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.fused_id = r_out.fid;
    assign o_result.is_new   = r_out.is_new;
    assign o_result.status   = r_out.status;

    // ---- assertions ----
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_act) <= 1)
        else $error("more than one search token in the cell chain");

    a_token_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_act != '0) |-> (r_state == fta_pkg::S_WALK))
        else $error("search token active outside a walk");

    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_next_id) |-> (r_next_id == $past(r_next_id) + fta_pkg::t_fid'(1)))
        else $error("fused id counter moved by other than one");

    a_new_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_walk_done && w_last.done && w_last.is_new) |->
            (w_last.fid == w_query.new_id && w_last.status == fta_pkg::ST_OK))
        else $error("allocated id does not follow the counter");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for fused_track_id_association: random and directed trace words,
// a scoreboard class that keeps its own association table, and handshake idling phases.
// Depends on fta_pkg and fta_if from the RTL.
`timescale 1ns / 1ps

module tb;

    import fta_pkg::*;

    // ------------------------------------------------------------------
    // Scoreboard: a private copy of the association table. Every accepted
    // trace word is run through it right away, and the predicted result
    // word is queued until the block hands its own one out.
    // ------------------------------------------------------------------
    class fused_id_scoreboard;
        bit      live      [ENTRIES];
        t_mask   slot_mask [ENTRIES];
        t_ids    slot_ids  [ENTRIES];
        t_fid    slot_fid  [ENTRIES];
        t_fid    last_fid;
        t_result expected_results[$];

        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned allocated;
        int unsigned reassociated;
        int unsigned empty_traces;
        int unsigned refused;

        function new();
            foreach (live[e]) begin
                live[e]      = 1'b0;
                slot_mask[e] = '0;
                slot_ids[e]  = '0;
                slot_fid[e]  = '0;
            end
            last_fid     = '0;
            mismatches   = 0;
            results_seen = 0;
            allocated    = 0;
            reassociated = 0;
            empty_traces = 0;
            refused      = 0;
        endfunction

        // walk in slot order; first entry that shares a slot and agrees on
        // every shared id wins and takes over the new trace
        function t_result associate(t_mask m, t_ids raw_ids);
            t_result r;
            t_ids    ids;
            t_mask   shared;
            int      free_e;
            bit      hit;
            r.fid    = '0;
            r.is_new = 1'b0;
            r.status = ST_OK;
            if (m == '0) begin
                r.status = ST_EMPTY;
                empty_traces++;
                return r;
            end
            // absent slots are stored as zero
            for (int s = 0; s < SENSORS; s++)
                ids[s] = m[s] ? raw_ids[s] : '0;
            free_e = -1;
            for (int e = 0; e < ENTRIES; e++) begin
                if (!live[e]) begin
                    if (free_e < 0)
                        free_e = e;
                    continue;
                end
                shared = slot_mask[e] & m;
                hit    = (shared != '0);
                for (int s = 0; s < SENSORS; s++)
                    if (shared[s] && slot_ids[e][s] != ids[s])
                        hit = 1'b0;
                if (hit) begin
                    slot_mask[e] = m;
                    slot_ids[e]  = ids;
                    r.fid        = slot_fid[e];
                    reassociated++;
                    return r;
                end
            end
            if (free_e < 0 || last_fid == '1) begin
                r.status = ST_FULL;
                refused++;
                return r;
            end
            last_fid++;
            live[free_e]      = 1'b1;
            slot_mask[free_e] = m;
            slot_ids[free_e]  = ids;
            slot_fid[free_e]  = last_fid;
            r.fid             = last_fid;
            r.is_new          = 1'b1;
            allocated++;
            return r;
        endfunction

        function void note_trace(t_mask m, t_ids ids);
            expected_results.push_back(associate(m, ids));
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] result word %0d: %s", $time, results_seen, msg);
        endtask

        task check_result(t_fid fid, logic is_new, logic [1:0] status);
            t_result want;
            results_seen++;
            if (expected_results.size() == 0) begin
                report("result word with no trace outstanding");
                return;
            end
            want = expected_results.pop_front();
            if (fid !== want.fid)
                report($sformatf("fused_id %0h, predicted %0h", fid, want.fid));
            if (is_new !== want.is_new)
                report($sformatf("is_new %b, predicted %b", is_new, want.is_new));
            if (status !== want.status)
                report($sformatf("status %0d, predicted %0d", status, want.status));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    fta_in_if  trace_if ();
    fta_out_if result_if ();

    fused_track_id_association dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_trace  (trace_if),
        .o_result (result_if)
    );

    fused_id_scoreboard board = new();

    // percent chance per cycle that the sender holds back / the receiver stalls
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned traces_sent = 0;

    localparam int RANDOM_PHASES    = 5;
    localparam int TRACES_PER_PHASE = 328;

    // ------------------------------------------------------------------
    // Result side: check every accepted result word, then pick the next ready.
    // Values read here are the ones from before the edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready)
            board.check_result(result_if.fused_id, result_if.is_new, result_if.status);
        result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Trace side
    // ------------------------------------------------------------------

    // Random gaps first, then hold the word until the block takes it.
    // Called at a rising edge; valid gets exactly one assignment per step.
    task automatic send_trace(t_mask m, t_ids ids);
        while ($urandom_range(0, 99) < idle_pct) begin
            trace_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        trace_if.valid        <= 1'b1;
        trace_if.present_mask <= m;
        trace_if.track_id_0   <= ids[0];
        trace_if.track_id_1   <= ids[1];
        trace_if.track_id_2   <= ids[2];
        trace_if.track_id_3   <= ids[3];
        do
            @(posedge i_clk);
        while (!trace_if.ready);
        board.note_trace(m, ids);
        traces_sent++;
    endtask

    // sender holds off until every outstanding result word is back
    task automatic drain_results();
        trace_if.valid <= 1'b0;
        while (board.expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Random trace word. Most are built from stored entries so that the walk
    // actually hits: clean matches (often on a superset or subset of slots),
    // near misses with one shared id flipped, and unions of two entries where
    // the first match in slot order has to win. A few are fresh traces and
    // empty masks. Ids of absent slots are random garbage the block must ignore.
    function automatic void pick_trace(output t_mask m, output t_ids ids);
        int unsigned kind;
        int unsigned a;
        int unsigned b;
        int unsigned s;
        logic [TRACK_ID_BITS-1:0] flip;
        for (int k = 0; k < SENSORS; k++)
            ids[k] = TRACK_ID_BITS'($urandom_range(0, (1 << TRACK_ID_BITS) - 1));
        m    = t_mask'($urandom_range(1, (1 << SENSORS) - 1));
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
            m = '0;
        end else if (kind >= 9 && board.allocated != 0) begin
            a = $urandom_range(0, board.allocated - 1);
            if (kind < 25 && kind >= 15) begin
                b = $urandom_range(0, board.allocated - 1);
                m = board.slot_mask[a] | board.slot_mask[b];
                for (int k = 0; k < SENSORS; k++)
                    if (board.slot_mask[a][k])
                        ids[k] = board.slot_ids[a][k];
                    else if (board.slot_mask[b][k])
                        ids[k] = board.slot_ids[b][k];
            end else begin
                do
                    s = $urandom_range(0, SENSORS - 1);
                while (!board.slot_mask[a][s]);
                m[s] = 1'b1;
                for (int k = 0; k < SENSORS; k++)
                    if (m[k] && board.slot_mask[a][k])
                        ids[k] = board.slot_ids[a][k];
                if (kind < 15) begin
                    flip   = TRACK_ID_BITS'($urandom_range(1, (1 << TRACK_ID_BITS) - 1));
                    ids[s] = ids[s] ^ flip;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_mask m;
        t_ids  ids;

        trace_if.valid        <= 1'b0;
        trace_if.present_mask <= '0;
        trace_if.track_id_0   <= '0;
        trace_if.track_id_1   <= '0;
        trace_if.track_id_2   <= '0;
        trace_if.track_id_3   <= '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme ids, empty traces, first match in slot order,
        // overwrite on match, new allocation on a conflicting shared slot.
        send_trace(4'b0000, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_trace(4'b0001, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000});
        send_trace(4'b0001, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_trace(4'b1111, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_trace(4'b0010, {16'h0000, 16'h0000, 16'hFFFF, 16'h5A5A});
        send_trace(4'b0011, {16'hA5A5, 16'hA5A5, 16'hFFFF, 16'h0000});
        send_trace(4'b0000, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_trace(4'b1000, {16'h8000, 16'h1234, 16'h0001, 16'h0002});
        send_trace(4'b0100, {16'hFFFF, 16'h1234, 16'hFFFF, 16'hFFFF});
        send_trace(4'b1100, {16'h8000, 16'h1234, 16'h0000, 16'h0000});
        send_trace(4'b1111, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_trace(4'b0110, {16'h0000, 16'h1234, 16'hFFFF, 16'h0000});
        send_trace(4'b1001, {16'h8000, 16'h0000, 16'h0000, 16'h0000});
        drain_results();

        // Random phases: no idling, sender idle, receiver stalling, both,
        // then a clean stretch again. Drained between phases.
        // The exhausted-id refusal needs 2^32 - 1 allocations and is not reached;
        // table-full refusals come once 64 entries have been handed out.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                1: begin
                    idle_pct  = 87;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 87;
                end
                3: begin
                    idle_pct  = 20;
                    stall_pct = 20;
                end
                default: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            for (int n = 0; n < TRACES_PER_PHASE; n++) begin
                pick_trace(m, ids);
                send_trace(m, ids);
            end
            drain_results();
        end

        // give any stray word time to show up after the last walk
        repeat (ENTRIES + 16) @(posedge i_clk);

        $display("covered %0d traces: %0d new ids, %0d re-associated, %0d empty, %0d refused",
                 traces_sent, board.allocated, board.reassociated, board.empty_traces,
                 board.refused);
        $display("handshake phases: free running, sender 87%% idle, receiver 87%% stall, both 20%%");
        if (board.mismatches == 0 && board.expected_results.size() == 0) begin
            $display("fused_track_id_association: match");
        end else begin
            $display("fused_track_id_association: mismatch");
        end
        $finish;
    end

    // watchdog: well over ten times the expected run length
    initial begin
        #6_000_000;
        $display("fused_track_id_association: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fta_pkg.sv
hw/rtl/fta_if.sv
hw/rtl/fta_cell.sv
hw/rtl/fused_track_id_association.sv
tb/sv/tb.sv
